### rtl/core/wrh_pkg.sv
// ----------------------------------------------------------------------------
// wrh_pkg
// Shared types, constants and the arctangent table of the wind rose histogram.
// ----------------------------------------------------------------------------
package wrh_pkg;

    localparam int CORDIC_STEPS = 28;
    localparam int STEP_W       = 5;
    localparam int NUM_EDGES    = 5;
    localparam int EDGE_W       = 16;
    localparam int CFG_IDX_W    = 3;
    localparam int FIELD_W      = 16;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_ONE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_TWO   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_THREE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_FOUR  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_FIVE  = 3'd4;

    localparam logic [STEP_W-1:0] LAST_STEP = 5'd27;

    typedef struct packed {
        logic signed [15:0] east_velocity;
        logic signed [15:0] north_velocity;
        logic               no_data;
        logic               last_sample;
    } sample_t;

    typedef struct packed {
        logic [3:0]  direction_index;
        logic [15:0] count_bin_zero;
        logic [15:0] count_bin_one;
        logic [15:0] count_bin_two;
        logic [15:0] count_bin_three;
        logic [15:0] count_bin_four;
        logic [15:0] count_bin_five;
        logic [15:0] direction_total;
        logic [15:0] grand_total;
        logic [15:0] no_data_total;
        logic [15:0] calm_total;
        logic        last_result;
    } result_t;

    typedef struct packed {
        logic              load;
        logic              step;
        logic [STEP_W-1:0] step_idx;
        logic              dir_calc;
        logic              mem_read;
        logic              mem_write;
        logic              emit_read;
        logic              emit_out;
        logic              emit_final;
    } cmd_t;

    typedef struct packed {
        logic in_skip;
        logic in_last;
        logic last;
    } status_t;

    // atan(2^-i) in binary angle units, 2^32 per turn
    function automatic logic [31:0] atan_turn(input logic [STEP_W-1:0] i);
        logic [31:0] t;
        begin
            unique case (i)
                5'd0:  t = 32'h20000000;
                5'd1:  t = 32'h12E4051E;
                5'd2:  t = 32'h09FB385B;
                5'd3:  t = 32'h051111D4;
                5'd4:  t = 32'h028B0D43;
                5'd5:  t = 32'h0145D7E1;
                5'd6:  t = 32'h00A2F61E;
                5'd7:  t = 32'h00517C55;
                5'd8:  t = 32'h0028BE53;
                5'd9:  t = 32'h00145F2F;
                5'd10: t = 32'h000A2F98;
                5'd11: t = 32'h000517CC;
                5'd12: t = 32'h00028BE6;
                5'd13: t = 32'h000145F3;
                5'd14: t = 32'h0000A2F9;
                5'd15: t = 32'h0000517D;
                5'd16: t = 32'h000028BE;
                5'd17: t = 32'h0000145F;
                5'd18: t = 32'h00000A30;
                5'd19: t = 32'h00000518;
                5'd20: t = 32'h0000028C;
                5'd21: t = 32'h00000146;
                5'd22: t = 32'h000000A3;
                5'd23: t = 32'h00000051;
                5'd24: t = 32'h00000029;
                5'd25: t = 32'h00000014;
                5'd26: t = 32'h0000000A;
                5'd27: t = 32'h00000005;
                default: t = 32'h0;
            endcase
            return t;
        end
    endfunction

endpackage

### rtl/core/wrh_ctrl.sv
// ----------------------------------------------------------------------------
// wrh_ctrl
// Sequencer: sample load, angle iterations, count update and frame emission.
// ----------------------------------------------------------------------------
module wrh_ctrl #(
    parameter int DIRECTION_BINS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  wrh_pkg::status_t                  status,
    output wrh_pkg::cmd_t                     cmd,
    output logic [$clog2(DIRECTION_BINS)-1:0] emit_idx,
    output logic                              busy
);

    localparam int DW = $clog2(DIRECTION_BINS);
    localparam logic [DW-1:0] LAST_DIR = DW'(DIRECTION_BINS - 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CORD = 3'd1;
    localparam logic [2:0] ST_DIR  = 3'd2;
    localparam logic [2:0] ST_RD   = 3'd3;
    localparam logic [2:0] ST_WR   = 3'd4;
    localparam logic [2:0] ST_ERD  = 3'd5;
    localparam logic [2:0] ST_EOUT = 3'd6;

    logic [2:0]                   state_reg, state_next;
    logic [wrh_pkg::STEP_W-1:0]   step_reg, step_next;
    logic [DW-1:0]                emit_reg, emit_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            emit_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            emit_reg  <= emit_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        emit_next  = emit_reg;
        cmd        = '0;
        cmd.step_idx = step_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load  = 1'b1;
                    step_next = '0;
                    emit_next = '0;
                    if (!status.in_skip)
                        state_next = ST_CORD;
                    else if (status.in_last)
                        state_next = ST_ERD;
                end
            end
            ST_CORD:
            begin
                cmd.step  = 1'b1;
                step_next = step_reg + 1'b1;
                if (step_reg == wrh_pkg::LAST_STEP)
                    state_next = ST_DIR;
            end
            ST_DIR:
            begin
                cmd.dir_calc = 1'b1;
                state_next   = ST_RD;
            end
            ST_RD:
            begin
                cmd.mem_read = 1'b1;
                state_next   = ST_WR;
            end
            ST_WR:
            begin
                cmd.mem_write = 1'b1;
                state_next    = status.last ? ST_ERD : ST_IDLE;
            end
            ST_ERD:
            begin
                cmd.emit_read = 1'b1;
                state_next    = ST_EOUT;
            end
            ST_EOUT:
            begin
                cmd.emit_out = 1'b1;
                if (emit_reg == LAST_DIR)
                begin
                    cmd.emit_final = 1'b1;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    emit_next  = emit_reg + 1'b1;
                    state_next = ST_ERD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign emit_idx = emit_reg;
    assign busy     = (state_reg != ST_IDLE);

endmodule

### rtl/core/wrh_datapath.sv
// ----------------------------------------------------------------------------
// wrh_datapath
// Edge registers, angle iteration unit, speed classifier, count memory,
// frame totals and result register.
// ----------------------------------------------------------------------------
module wrh_datapath #(
    parameter int DIRECTION_BINS = 16,
    parameter int SPEED_BINS     = 6,
    parameter int COUNT_WIDTH    = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  wrh_pkg::cmd_t                         cmd,
    input  logic [$clog2(DIRECTION_BINS)-1:0]     emit_idx,
    input  wrh_pkg::sample_t                      sample,
    input  logic                                  cfg_write,
    input  logic [wrh_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [wrh_pkg::EDGE_W-1:0]            cfg_data,
    output wrh_pkg::status_t                      status,
    output wrh_pkg::result_t                      result,
    output logic                                  result_valid
);

    localparam int DW    = $clog2(DIRECTION_BINS);
    localparam int SBW   = (SPEED_BINS > 2) ? $clog2(SPEED_BINS) : 1;
    localparam int CW    = COUNT_WIDTH;
    localparam int ROW_W = SPEED_BINS * CW;
    localparam int PW    = 33 + DW;
    localparam logic [CW-1:0] COUNT_MAX = {CW{1'b1}};
    localparam logic [DW:0]   DIR_WRAP  = (DW+1)'(DIRECTION_BINS);

    logic [wrh_pkg::EDGE_W-1:0] edge_reg [wrh_pkg::NUM_EDGES];

    logic signed [33:0] x_reg, y_reg;
    logic [31:0]        ang_reg;
    logic [31:0]        esq_reg, nsq_reg, mag2_reg;
    logic [SBW-1:0]     sb_reg;
    logic               found_reg;
    logic               last_reg;
    logic [DW-1:0]      dir_reg;

    logic [ROW_W-1:0]   mem [DIRECTION_BINS];
    logic [DIRECTION_BINS-1:0] row_valid_reg;
    logic [ROW_W-1:0]   rd_data_reg;
    logic               rd_valid_reg;

    logic [CW-1:0]      binned_reg, invalid_reg, still_reg;
    wrh_pkg::result_t   result_reg;
    logic               result_valid_reg;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_reg[0] <= 16'd256;
            edge_reg[1] <= 16'd512;
            edge_reg[2] <= 16'd768;
            edge_reg[3] <= 16'd1024;
            edge_reg[4] <= 16'd1280;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                wrh_pkg::REG_EDGE_ONE:   edge_reg[0] <= cfg_data;
                wrh_pkg::REG_EDGE_TWO:   edge_reg[1] <= cfg_data;
                wrh_pkg::REG_EDGE_THREE: edge_reg[2] <= cfg_data;
                wrh_pkg::REG_EDGE_FOUR:  edge_reg[3] <= cfg_data;
                wrh_pkg::REG_EDGE_FIVE:  edge_reg[4] <= cfg_data;
                default: ;
            endcase
        end
    end

    // sample classification straight from the port
    logic in_zero;
    assign in_zero = (sample.east_velocity == 16'sd0) && (sample.north_velocity == 16'sd0);
    assign status.in_skip = sample.no_data || in_zero;
    assign status.in_last = sample.last_sample;
    assign status.last    = last_reg;

    // start vector, folded into the right half plane
    logic signed [33:0] e_sc, n_sc, x_init, y_init;
    logic signed [31:0] esq, nsq;
    always_comb
    begin
        e_sc = 34'(sample.east_velocity) <<< 14;
        n_sc = 34'(sample.north_velocity) <<< 14;
        x_init = (sample.north_velocity > 16'sd0) ? n_sc : -n_sc;
        y_init = (sample.north_velocity > 16'sd0) ? e_sc : -e_sc;
        esq = sample.east_velocity * sample.east_velocity;
        nsq = sample.north_velocity * sample.north_velocity;
    end

    // one rotation step
    logic signed [33:0] dx, dy;
    logic [31:0]        t_step;
    assign dx     = y_reg >>> cmd.step_idx;
    assign dy     = x_reg >>> cmd.step_idx;
    assign t_step = wrh_pkg::atan_turn(cmd.step_idx);

    // speed edge test, one edge per step starting at step one
    logic [2:0]  eidx;
    logic [15:0] edge_sel;
    logic [31:0] edge_sq;
    logic        edge_test;
    always_comb
    begin
        eidx      = 3'(cmd.step_idx - 5'd1);
        edge_sel  = (eidx < 3'(wrh_pkg::NUM_EDGES)) ? edge_reg[eidx] : 16'd0;
        edge_sq   = edge_sel * edge_sel;
        edge_test = (cmd.step_idx != 5'd0)
                 && (cmd.step_idx <= 5'(SPEED_BINS - 1));
    end

    // sector from the angle, rounded to nearest with wrap
    logic [PW-1:0] dir_prod;
    logic [DW:0]   dir_q;
    always_comb
    begin
        dir_prod = PW'(ang_reg) * PW'(DIRECTION_BINS) + PW'(33'h080000000);
        dir_q    = dir_prod[PW-1:32];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg     <= x_init;
            y_reg     <= y_init;
            ang_reg   <= (sample.north_velocity > 16'sd0) ? 32'h80000000 : 32'h0;
            esq_reg   <= 32'(esq);
            nsq_reg   <= 32'(nsq);
            sb_reg    <= SBW'(SPEED_BINS - 1);
            found_reg <= 1'b0;
            last_reg  <= sample.last_sample;
        end
        else if (cmd.step)
        begin
            if (y_reg > 34'sd0)
            begin
                x_reg   <= x_reg + dx;
                y_reg   <= y_reg - dy;
                ang_reg <= ang_reg + t_step;
            end
            else
            begin
                x_reg   <= x_reg - dx;
                y_reg   <= y_reg + dy;
                ang_reg <= ang_reg - t_step;
            end
            if (cmd.step_idx == 5'd0)
                mag2_reg <= esq_reg + nsq_reg;
            else if (edge_test && !found_reg && (mag2_reg < edge_sq))
            begin
                sb_reg    <= SBW'(eidx);
                found_reg <= 1'b1;
            end
        end
        if (cmd.dir_calc)
            dir_reg <= (dir_q == DIR_WRAP) ? '0 : dir_q[DW-1:0];
    end

    // count memory, one row of speed counts per sector
    logic [DW-1:0]    rd_addr;
    logic [ROW_W-1:0] row_cur, row_inc;
    assign rd_addr = cmd.emit_read ? emit_idx : dir_reg;
    assign row_cur = rd_valid_reg ? rd_data_reg : '0;

    always_comb
    begin
        row_inc = row_cur;
        for (int s = 0; s < SPEED_BINS; s++)
        begin
            if (sb_reg == SBW'(s) && row_cur[s*CW +: CW] != COUNT_MAX)
                row_inc[s*CW +: CW] = row_cur[s*CW +: CW] + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mem_read || cmd.emit_read)
            rd_data_reg <= mem[rd_addr];
        if (cmd.mem_write)
            mem[dir_reg] <= row_inc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.mem_read || cmd.emit_read)
                rd_valid_reg <= row_valid_reg[rd_addr];
            if (cmd.mem_write)
                row_valid_reg[dir_reg] <= 1'b1;
            else if (cmd.emit_out)
                row_valid_reg[emit_idx] <= 1'b0;
        end
    end

    // frame totals
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            binned_reg  <= '0;
            invalid_reg <= '0;
            still_reg   <= '0;
        end
        else if (cmd.emit_final)
        begin
            binned_reg  <= '0;
            invalid_reg <= '0;
            still_reg   <= '0;
        end
        else
        begin
            if (cmd.load && sample.no_data && invalid_reg != COUNT_MAX)
                invalid_reg <= invalid_reg + 1'b1;
            if (cmd.load && !sample.no_data && in_zero && still_reg != COUNT_MAX)
                still_reg <= still_reg + 1'b1;
            if (cmd.mem_write && binned_reg != COUNT_MAX)
                binned_reg <= binned_reg + 1'b1;
        end
    end

    // result assembly
    logic [15:0]    cnt16 [6];
    logic [CW+2:0]  row_sum;
    logic [CW-1:0]  row_tot;
    always_comb
    begin
        row_sum = '0;
        for (int k = 0; k < 6; k++)
        begin
            cnt16[k] = 16'd0;
            if (k < SPEED_BINS)
            begin
                cnt16[k] = 16'(row_cur[k*CW +: CW]);
                row_sum  = row_sum + (CW+3)'(row_cur[k*CW +: CW]);
            end
        end
        row_tot = (row_sum > (CW+3)'(COUNT_MAX)) ? COUNT_MAX : row_sum[CW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_out)
        begin
            result_reg.direction_index <= 4'(emit_idx);
            result_reg.count_bin_zero  <= cnt16[0];
            result_reg.count_bin_one   <= cnt16[1];
            result_reg.count_bin_two   <= cnt16[2];
            result_reg.count_bin_three <= cnt16[3];
            result_reg.count_bin_four  <= cnt16[4];
            result_reg.count_bin_five  <= cnt16[5];
            result_reg.direction_total <= 16'(row_tot);
            result_reg.grand_total     <= 16'(binned_reg);
            result_reg.no_data_total   <= 16'(invalid_reg);
            result_reg.calm_total      <= 16'(still_reg);
            result_reg.last_result     <= cmd.emit_final;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else
            result_valid_reg <= cmd.emit_out;
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

endmodule

### rtl/core/wind_rose_histogram.sv
// ----------------------------------------------------------------------------
// wind_rose_histogram
// Direction/speed histogram of a frame of flow vectors, one row per sector.
// ----------------------------------------------------------------------------
// A sample is taken when start is high and busy is low. A no-data or calm
// sample is done in its load step alone; a binned sample passes the load,
// the angle iterations in the shared angle rotation unit, the sector step,
// and a read then a write of the count memory. A sample marked last_sample
// is followed by the frame dump: one transaction per sector on
// result_valid, each from a memory read, then the result register. The
// receiver cannot stall: each result is shown for exactly one cycle. Counts
// are clear after reset and again after the last result of a frame; no
// clearing pass is needed. Edge registers are to be written through
// cfg_write while busy is low; the block itself does not enforce it.
module wind_rose_histogram #(
    parameter int DIRECTION_BINS = 16,
    parameter int SPEED_BINS     = 6,
    parameter int COUNT_WIDTH    = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  wrh_pkg::sample_t              sample,
    input  logic                          cfg_write,
    input  logic [wrh_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [wrh_pkg::EDGE_W-1:0]    cfg_data,
    output wrh_pkg::result_t              result,
    output logic                          result_valid
);

    wrh_pkg::cmd_t                     cmd;
    wrh_pkg::status_t                  status;
    logic [$clog2(DIRECTION_BINS)-1:0] emit_idx;

    wrh_ctrl #(
        .DIRECTION_BINS(DIRECTION_BINS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .status   (status),
        .cmd      (cmd),
        .emit_idx (emit_idx),
        .busy     (busy)
    );

    wrh_datapath #(
        .DIRECTION_BINS(DIRECTION_BINS),
        .SPEED_BINS    (SPEED_BINS),
        .COUNT_WIDTH   (COUNT_WIDTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .emit_idx     (emit_idx),
        .sample       (sample),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .status       (status),
        .result       (result),
        .result_valid (result_valid)
    );

`ifndef SYNTHESIS
    // result strobes never come back to back
    a_result_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("back-to-back result strobes");

    // only the final result of a frame may arrive with the block idle
    a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last_result |-> busy)
        else $error("result outside a frame dump");

    // a last sample always starts a dump
    a_last_dump: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && sample.last_sample |=> busy)
        else $error("last sample did not start a dump");
`endif

endmodule
